@@ hdl/cws_pkg.sv @@
// Shared types and constants for the cheapest window search block.
// Used by every module in hdl/; depends on nothing else.
`default_nettype none

package cws_pkg;

	// Window geometry and batch limits.
	localparam int WINDOW_LEN  = 6;
	localparam int MAX_ENTRIES = 256;

	// Field widths.
	localparam int PRICE_W  = 24;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int IDX_W    = 8;
	localparam int CFG_W    = 5;
	localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
	localparam int SUM_W    = PRICE_W + $clog2(WINDOW_LEN);

	// Time arithmetic.
	localparam int ENTRY_MINUTES = 15;
	localparam int HOUR_MINUTES  = 60;
	localparam int DAY_HOURS     = 24;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_EARLIEST_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LATEST_END     = 1'd1;

	// Register reset values.
	localparam logic [CFG_W-1:0] EARLIEST_START_RST = 5'd7;
	localparam logic [CFG_W-1:0] LATEST_END_RST     = 5'd23;

	// Floor division by the window length through a reciprocal multiply.
	// The bias makes the sum non-negative and is a multiple of the window length.
	localparam int     DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
	localparam int     RECIP_W   = DIV_SHIFT - $clog2(WINDOW_LEN) + 1;
	localparam longint RECIP     = ((longint'(1) << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
	localparam longint DIV_BIAS  = longint'(WINDOW_LEN) << (PRICE_W - 1);

	// One input item.
	typedef struct packed {
		logic signed [PRICE_W-1:0] price;
		logic [HOUR_W-1:0]         hour;
		logic [MINUTE_W-1:0]       minute;
		logic                      last;
	} item_t;

	// Batch result before the average is formed.
	typedef struct packed {
		logic                    found;
		logic signed [SUM_W-1:0] sum;
		logic [IDX_W-1:0]        index;
		logic                    ovf;
	} result_t;

endpackage

`default_nettype wire

@@ hdl/cheapest_window_search.sv @@
// Top level of the cheapest window search block.
// Instantiates cws_window and cws_floor_div; depends on cws_pkg.
`default_nettype none

// Prices arrive one quarter-hour entry per transfer and the block accepts a new
// entry every clock cycle while no staged entry marked last is held back. Each
// entry is captured in an input register and then folded from there into the
// six-entry window, its running sum and the best-window record. The transfer
// marked last produces one result, held in an output register until it is taken,
// and clears the batch. Input transfers keep flowing while a result waits; only a
// second entry marked last waits for the output register to drain. The user must
// write registers through cfg_we, cfg_index and cfg_data only while no batch is
// in flight; the block itself does not enforce this.
module cheapest_window_search import cws_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [PRICE_W-1:0]  price,
	input  wire logic [HOUR_W-1:0]          hour,
	input  wire logic [MINUTE_W-1:0]        minute,
	input  wire logic                       last,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            found,
	output logic signed [PRICE_W-1:0]       best_average,
	output logic [IDX_W-1:0]                best_start_index,
	output logic                            overflow
);

	logic [CFG_W-1:0] earliest_q;
	logic [CFG_W-1:0] latest_q;
	item_t            item_s1;
	logic             valid_s1;
	result_t          res_comb;
	result_t          res_q;
	logic             out_valid_q;
	logic             out_free;
	logic             adv;
	logic             emit;
	logic signed [PRICE_W-1:0] avg;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			earliest_q <= EARLIEST_START_RST;
			latest_q   <= LATEST_END_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EARLIEST_START: earliest_q <= cfg_data;
				REG_LATEST_END:     latest_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the staged entry moves on unless it is last and the result slot is busy.
	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && (!item_s1.last || out_free);
	assign emit     = adv && item_s1.last;
	assign in_ready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.price  <= price;
			item_s1.hour   <= hour;
			item_s1.minute <= minute;
			item_s1.last   <= last;
		end
	end

	cws_window u_window (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (adv),
		.item                (item_s1),
		.earliest_start_hour (earliest_q),
		.latest_end_hour     (latest_q),
		.res                 (res_comb)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_comb;
		end
	end

	cws_floor_div u_floor_div (
		.sum     (res_q.sum),
		.average (avg)
	);

	// Output fields; an empty batch reports zeros.
	assign out_valid        = out_valid_q;
	assign found            = res_q.found;
	assign best_average     = res_q.found ? avg : '0;
	assign best_start_index = res_q.found ? res_q.index : '0;
	assign overflow         = res_q.ovf;

endmodule

`default_nettype wire

@@ hdl/cws_window.sv @@
// Sliding window state, running sum, qualification and best-window tracking.
// Depends on cws_pkg.
`default_nettype none

module cws_window import cws_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire item_t            item,
	input  wire logic [CFG_W-1:0] earliest_start_hour,
	input  wire logic [CFG_W-1:0] latest_end_hour,
	output result_t               res
);

	logic signed [PRICE_W-1:0] price_win_q [WINDOW_LEN];
	logic [HOUR_W-1:0]         hour_win_q  [WINDOW_LEN];
	logic [CNT_W-1:0]          count_q;
	logic signed [SUM_W-1:0]   win_sum_q;
	logic signed [SUM_W-1:0]   best_sum_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic                      found_q;
	logic                      ovf_q;

	logic                      room;
	logic [CNT_W-1:0]          cnt_inc;
	logic signed [SUM_W-1:0]   sum_next;
	logic [HOUR_W-1:0]         start_hour;
	logic [MINUTE_W:0]         end_min_raw;
	logic [MINUTE_W:0]         end_min;
	logic [HOUR_W:0]           end_hour_inc;
	logic [HOUR_W:0]           end_hour;
	logic                      qual;
	logic                      take;
	logic [IDX_W-1:0]          idx_new;

	// Running sum: add the arriving price, drop the oldest one.
	assign room     = count_q < CNT_W'(MAX_ENTRIES);
	assign cnt_inc  = count_q + CNT_W'(1);
	assign sum_next = win_sum_q + SUM_W'(item.price) - SUM_W'(price_win_q[0]);
	assign idx_new  = IDX_W'(cnt_inc - CNT_W'(WINDOW_LEN));

	// After the shift, the window's first entry is the current second entry.
	assign start_hour = hour_win_q[1];

	// End time of the window: start of the arriving entry plus one quarter hour.
	always_comb begin
		end_min_raw  = (MINUTE_W+1)'(item.minute) + (MINUTE_W+1)'(ENTRY_MINUTES);
		end_hour_inc = (HOUR_W+1)'(item.hour) + (HOUR_W+1)'(1);
		end_min      = end_min_raw;
		end_hour     = (HOUR_W+1)'(item.hour);
		if (end_min_raw >= (MINUTE_W+1)'(HOUR_MINUTES)) begin
			end_min  = end_min_raw - (MINUTE_W+1)'(HOUR_MINUTES);
			end_hour = (end_hour_inc >= (HOUR_W+1)'(DAY_HOURS)) ? '0 : end_hour_inc;
		end
	end

	// Window qualification against the configured hours.
	always_comb begin
		qual = (start_hour >= earliest_start_hour)
			&& ((end_hour < (HOUR_W+1)'(latest_end_hour))
				|| ((end_hour == (HOUR_W+1)'(latest_end_hour)) && (end_min == '0)))
			&& !(end_hour < (HOUR_W+1)'(start_hour));
	end

	// A full qualifying window with a strictly lower sum replaces the best.
	assign take = room && (cnt_inc >= CNT_W'(WINDOW_LEN)) && qual
		&& (!found_q || (sum_next < best_sum_q));

	// Result as it stands once this item is counted.
	always_comb begin
		res.found = found_q || take;
		res.sum   = take ? sum_next : best_sum_q;
		res.index = take ? idx_new : best_idx_q;
		res.ovf   = ovf_q || !room;
	end

	// Batch state; the entry marked last clears everything.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW_LEN; k++) begin
				price_win_q[k] <= '0;
				hour_win_q[k]  <= '0;
			end
			count_q    <= '0;
			win_sum_q  <= '0;
			best_sum_q <= '0;
			best_idx_q <= '0;
			found_q    <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (step) begin
			if (item.last) begin
				for (int k = 0; k < WINDOW_LEN; k++) begin
					price_win_q[k] <= '0;
					hour_win_q[k]  <= '0;
				end
				count_q    <= '0;
				win_sum_q  <= '0;
				best_sum_q <= '0;
				best_idx_q <= '0;
				found_q    <= 1'b0;
				ovf_q      <= 1'b0;
			end else begin
				if (room) begin
					for (int k = 0; k < WINDOW_LEN - 1; k++) begin
						price_win_q[k] <= price_win_q[k+1];
						hour_win_q[k]  <= hour_win_q[k+1];
					end
					price_win_q[WINDOW_LEN-1] <= item.price;
					hour_win_q[WINDOW_LEN-1]  <= item.hour;
					count_q   <= cnt_inc;
					win_sum_q <= sum_next;
				end else begin
					ovf_q <= 1'b1;
				end
				if (take) begin
					best_sum_q <= sum_next;
					best_idx_q <= idx_new;
					found_q    <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/cws_floor_div.sv @@
// Floored division of a window sum by the window length.
// Uses a biased reciprocal multiply; depends on cws_pkg.
`default_nettype none

module cws_floor_div import cws_pkg::*; (
	input  wire logic signed [SUM_W-1:0] sum,
	output logic signed [PRICE_W-1:0]    average
);

	logic [SUM_W-1:0]         biased;
	logic [SUM_W+RECIP_W-1:0] prod;

	// Shift the sum into the non-negative range, divide, then remove the bias.
	assign biased  = unsigned'(sum) + SUM_W'(DIV_BIAS);
	assign prod    = (SUM_W+RECIP_W)'(biased) * (SUM_W+RECIP_W)'(RECIP);
	assign average = signed'(prod[DIV_SHIFT +: PRICE_W]
		^ {1'b1, {(PRICE_W-1){1'b0}}});

endmodule

`default_nettype wire
